FILE: hw/rtl/umtr_pkg.sv
// Shared types, opcode codes and instruction encodings for the UM to AArch64 translator.
package umtr_pkg;

  // Guest opcodes, bits 31..28 of the instruction word
  localparam logic [3:0] OP_CMOV   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_STORE  = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_MUL    = 4'd4;
  localparam logic [3:0] OP_DIV    = 4'd5;
  localparam logic [3:0] OP_NAND   = 4'd6;
  localparam logic [3:0] OP_HALT   = 4'd7;
  localparam logic [3:0] OP_MAP    = 4'd8;
  localparam logic [3:0] OP_SEGFREE = 4'd9;
  localparam logic [3:0] OP_OUT    = 4'd10;
  localparam logic [3:0] OP_IN     = 4'd11;
  localparam logic [3:0] OP_LOADP  = 4'd12;
  localparam logic [3:0] OP_LOADV  = 4'd13;

  // Configuration register indexes
  localparam logic [2:0] CFG_BASE_REG  = 3'd0;
  localparam logic [2:0] CFG_ARG_REG   = 3'd1;
  localparam logic [2:0] CFG_OUT_CODE  = 3'd2;
  localparam logic [2:0] CFG_IN_CODE   = 3'd3;
  localparam logic [2:0] CFG_UNMAP_CODE = 3'd4;

  localparam logic [4:0]  BASE_REG_RST   = 5'd19;
  localparam logic [4:0]  ARG_REG_RST    = 5'd1;
  localparam logic [15:0] OUT_CODE_RST   = 16'd0;
  localparam logic [15:0] IN_CODE_RST    = 16'd1;
  localparam logic [15:0] UNMAP_CODE_RST = 16'd2;

  localparam logic [24:0] SLOT_BYTES = 25'd20;

  // AArch64 encodings
  localparam logic [31:0] NOP_WORD    = 32'hD503201F;
  localparam logic [31:0] MOVZ_W      = 32'h52800000;
  localparam logic [31:0] MOVK_W_HI   = 32'h72A00000;
  localparam logic [31:0] MOV_W_REG   = 32'h2A0003E0;
  localparam logic [31:0] CMP_W       = 32'h7100001F;
  localparam logic [31:0] CSEL_W      = 32'h1A800000;
  localparam logic [31:0] CSEL_COND   = 32'h00001000;
  localparam logic [31:0] ADD_X9_X28  = 32'h8B000389;
  localparam logic [31:0] LDR_W_IDX   = 32'hB8605920;
  localparam logic [31:0] STR_W_IDX   = 32'hB8205920;
  localparam logic [31:0] ADD_W       = 32'h0B000000;
  localparam logic [31:0] MADD_W      = 32'h1B000000;
  localparam logic [31:0] MADD_ZR    = 32'h00007C00;
  localparam logic [31:0] UDIV_W      = 32'h1AC00800;
  localparam logic [31:0] AND_W       = 32'h0A000000;
  localparam logic [31:0] ORN_W       = 32'h2A2003E0;
  localparam logic [31:0] W9_RD       = 32'h00000009;
  localparam logic [31:0] W9_RM       = 32'h00090000;
  localparam logic [31:0] MOVZ_X27    = 32'hD280001B;
  localparam logic [31:0] RET_WORD    = 32'hD65F03C0;
  localparam logic [31:0] STR_LR_PUSH = 32'hF81F0FFE;
  localparam logic [31:0] LDR_LR_POP  = 32'hF84107FE;
  localparam logic [31:0] BLR_X12     = 32'hD63F0180;
  localparam logic [31:0] BLR_X15     = 32'hD63F01E0;
  localparam logic [31:0] BR_X15      = 32'hD61F01E0;
  localparam logic [31:0] ADR_X13_8   = 32'h1000004D;
  localparam logic [31:0] MOV_W10     = 32'h2A0003EA;
  localparam logic [31:0] CBNZ_W_2    = 32'h35000040;

  // Classified instruction, host registers already mapped
  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [4:0]  rc;
    logic [4:0]  rd;
    logic [24:0] imm;
    logic [24:0] next_offset;
  } dec_t;

  typedef struct packed {
    logic [4:0]  arg_reg;
    logic [15:0] out_code;
    logic [15:0] in_code;
    logic [15:0] unmap_code;
  } svc_cfg_t;

  function automatic logic [31:0] f_rd(input logic [4:0] r);
    return {27'b0, r};
  endfunction

  function automatic logic [31:0] f_rn(input logic [4:0] r);
    return {22'b0, r, 5'b0};
  endfunction

  function automatic logic [31:0] f_rm(input logic [4:0] r);
    return {11'b0, r, 16'b0};
  endfunction

  function automatic logic [31:0] f_imm16(input logic [15:0] v);
    return {11'b0, v, 5'b0};
  endfunction

endpackage

FILE: hw/rtl/umtr_front.sv
// Front end: configuration registers, input acceptance and instruction classification.
module umtr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              guest_instruction,
  input  logic [23:0]              code_offset,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     q_full,
  output logic                     push,
  output umtr_pkg::dec_t           push_data,
  output umtr_pkg::svc_cfg_t       svc_cfg
);
  import umtr_pkg::*;

  logic [4:0] base_register;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_register      <= BASE_REG_RST;
      svc_cfg.arg_reg    <= ARG_REG_RST;
      svc_cfg.out_code   <= OUT_CODE_RST;
      svc_cfg.in_code    <= IN_CODE_RST;
      svc_cfg.unmap_code <= UNMAP_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_REG:   base_register      <= cfg_data[4:0];
        CFG_ARG_REG:    svc_cfg.arg_reg    <= cfg_data[4:0];
        CFG_OUT_CODE:   svc_cfg.out_code   <= cfg_data;
        CFG_IN_CODE:    svc_cfg.in_code    <= cfg_data;
        CFG_UNMAP_CODE: svc_cfg.unmap_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // 5-bit adds wrap mod 32 like the host register file numbering
  always_comb begin
    push_data.op          = guest_instruction[31:28];
    push_data.ra          = base_register + {2'b0, guest_instruction[8:6]};
    push_data.rb          = base_register + {2'b0, guest_instruction[5:3]};
    push_data.rc          = base_register + {2'b0, guest_instruction[2:0]};
    push_data.rd          = base_register + {2'b0, guest_instruction[27:25]};
    push_data.imm         = guest_instruction[24:0];
    push_data.next_offset = {1'b0, code_offset} + SLOT_BYTES;
  end

endmodule

FILE: hw/rtl/umtr_queue.sv
// Short FIFO of classified instructions between the front and back ends.
module umtr_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  umtr_pkg::dec_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output umtr_pkg::dec_t head_data
);
  import umtr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dec_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= f_inc(wr_ptr);
      if (pop)  rd_ptr <= f_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/umtr_back.sv
// Back end: builds the five-word AArch64 slot and holds it in the output register.
module umtr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  umtr_pkg::dec_t     head_data,
  input  umtr_pkg::svc_cfg_t svc_cfg,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        host_word0,
  output logic [31:0]        host_word1,
  output logic [31:0]        host_word2,
  output logic [31:0]        host_word3,
  output logic [31:0]        host_word4,
  output logic [24:0]        next_offset
);
  import umtr_pkg::*;

  logic [31:0] w0, w1, w2, w3, w4;
  logic [31:0] svc_out, svc_in, svc_unmap;
  logic [31:0] arg;

  assign pop = head_valid && (!out_valid || out_ready);

  assign arg       = f_rd(svc_cfg.arg_reg);
  assign svc_out   = MOVZ_W | f_imm16(svc_cfg.out_code) | arg;
  assign svc_in    = MOVZ_W | f_imm16(svc_cfg.in_code) | arg;
  assign svc_unmap = MOVZ_W | f_imm16(svc_cfg.unmap_code) | arg;

  always_comb begin
    dec_t d;
    d  = head_data;
    w0 = NOP_WORD;
    w1 = NOP_WORD;
    w2 = NOP_WORD;
    w3 = NOP_WORD;
    w4 = NOP_WORD;
    unique case (d.op)
      OP_CMOV: begin
        w0 = CMP_W | f_rn(d.rc);
        w1 = CSEL_W | f_rd(d.ra) | f_rn(d.rb) | f_rm(d.ra) | CSEL_COND;
      end
      OP_LOAD: begin
        w0 = ADD_X9_X28 | f_rm(d.rb);
        w1 = LDR_W_IDX | f_rd(d.ra) | f_rm(d.rc);
      end
      OP_STORE: begin
        w0 = ADD_X9_X28 | f_rm(d.ra);
        w1 = STR_W_IDX | f_rd(d.rc) | f_rm(d.rb);
      end
      OP_ADD:  w0 = ADD_W | f_rd(d.ra) | f_rn(d.rb) | f_rm(d.rc);
      OP_MUL:  w0 = MADD_W | f_rd(d.ra) | f_rn(d.rb) | f_rm(d.rc) | MADD_ZR;
      OP_DIV:  w0 = UDIV_W | f_rd(d.ra) | f_rn(d.rb) | f_rm(d.rc);
      OP_NAND: begin
        w0 = AND_W | W9_RD | f_rn(d.rb) | f_rm(d.rc);
        w1 = ORN_W | f_rd(d.ra) | W9_RM;
      end
      OP_HALT: begin
        w0 = MOVZ_X27;
        w1 = RET_WORD;
        w2 = '0;
        w3 = '0;
        w4 = '0;
      end
      OP_MAP: begin
        w0 = MOV_W_REG | f_rm(d.rc);
        w1 = STR_LR_PUSH;
        w2 = BLR_X12;
        w3 = LDR_LR_POP;
        w4 = MOV_W_REG | f_rd(d.rb);
      end
      OP_SEGFREE: begin
        w0 = MOV_W_REG | f_rm(d.rc);
        w1 = svc_unmap;
        w2 = STR_LR_PUSH;
        w3 = BLR_X15;
        w4 = LDR_LR_POP;
      end
      OP_OUT: begin
        w0 = MOV_W_REG | f_rm(d.rc);
        w1 = svc_out;
        w2 = ADR_X13_8;
        w3 = BR_X15;
      end
      OP_IN: begin
        w0 = svc_in;
        w1 = ADR_X13_8;
        w2 = BR_X15;
        w3 = MOV_W_REG | f_rd(d.rc);
      end
      OP_LOADP: begin
        w0 = MOV_W10 | f_rm(d.rc);
        w1 = CBNZ_W_2 | f_rd(d.rb);
        w2 = RET_WORD;
        w3 = MOV_W_REG | f_rm(d.rb);
        w4 = BR_X15;
      end
      OP_LOADV: begin
        w0 = MOVZ_W | f_imm16(d.imm[15:0]) | f_rd(d.rd);
        w1 = MOVK_W_HI | f_imm16({7'b0, d.imm[24:16]}) | f_rd(d.rd);
      end
      default: begin
        // opcodes 14 and 15: empty slot
        w0 = '0;
        w1 = '0;
        w2 = '0;
        w3 = '0;
        w4 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      host_word0  <= w0;
      host_word1  <= w1;
      host_word2  <= w2;
      host_word3  <= w3;
      host_word4  <= w4;
      next_offset <= head_data.next_offset;
    end
  end

endmodule

FILE: hw/rtl/um_to_arm64_instruction_translator.sv
// Top level of the Universal Machine to AArch64 instruction translator.
// Translates one UM instruction word per cycle into a 20-byte slot of five AArch64
// words plus the next slot offset. An input transaction passes through the
// classification queue and then the output register of the slot builder before
// output valid. Throughput is one transaction per cycle while out_ready stays high, set by the single
// queue read port and the output register; the queue absorbs up to QUEUE_DEPTH
// instructions while the output side stalls. Configuration writes are taken at once
// (cfg_ready is tied high) and must be made while no translation is in flight.
module um_to_arm64_instruction_translator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] guest_instruction,
  input  logic [23:0] code_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] host_word0,
  output logic [31:0] host_word1,
  output logic [31:0] host_word2,
  output logic [31:0] host_word3,
  output logic [31:0] host_word4,
  output logic [24:0] next_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import umtr_pkg::*;

  logic     q_full;
  logic     push;
  logic     pop;
  logic     head_valid;
  dec_t     push_data;
  dec_t     head_data;
  svc_cfg_t svc_cfg;

  umtr_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .guest_instruction (guest_instruction),
    .code_offset       (code_offset),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_full            (q_full),
    .push              (push),
    .push_data         (push_data),
    .svc_cfg           (svc_cfg)
  );

  umtr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  umtr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .svc_cfg     (svc_cfg),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .host_word0  (host_word0),
    .host_word1  (host_word1),
    .host_word2  (host_word2),
    .host_word3  (host_word3),
    .host_word4  (host_word4),
    .next_offset (next_offset)
  );

endmodule

FILE: hw/rtl/umtr_checker.sv
// Port-level checks for the translator, bound to the top level.
module umtr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] host_word0,
  input logic [31:0] host_word1,
  input logic [31:0] host_word2,
  input logic [31:0] host_word3,
  input logic [31:0] host_word4,
  input logic [24:0] next_offset
);

  // a stalled result transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(host_word0) && $stable(next_offset))
    else $error("output transaction dropped or changed while stalled");

  a_offset_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> next_offset >= 25'd20)
    else $error("next_offset below one slot");

  // only halt and invalid slots have a zero third word, and both zero the tail
  a_zero_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && host_word2 == 32'h0 |-> host_word3 == 32'h0 && host_word4 == 32'h0)
    else $error("partial zero tail in slot");

  // a zero first word means an invalid opcode: whole slot empty
  a_invalid_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && host_word0 == 32'h0 |-> host_word1 == 32'h0 && host_word2 == 32'h0)
    else $error("invalid slot not fully zero");

endmodule

bind um_to_arm64_instruction_translator umtr_checker u_umtr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .host_word0  (host_word0),
  .host_word1  (host_word1),
  .host_word2  (host_word2),
  .host_word3  (host_word3),
  .host_word4  (host_word4),
  .next_offset (next_offset)
);

FILE: tb/um_slot_checker.sv
// Checker that predicts each translated slot and compares it with the translator's output.
module um_slot_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] guest_instruction,
  input  logic [23:0] code_offset,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] host_word0,
  input  logic [31:0] host_word1,
  input  logic [31:0] host_word2,
  input  logic [31:0] host_word3,
  input  logic [31:0] host_word4,
  input  logic [24:0] next_offset,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          error_count,
  output int          in_flight
);
  import umtr_pkg::*;

  localparam int MAX_REPORTS = 10;

  // AArch64 encodings, kept separate from the design's own copies
  localparam logic [31:0] ENC_NOP       = 32'hD503201F;
  localparam logic [31:0] ENC_MOVZ      = 32'h52800000;
  localparam logic [31:0] ENC_MOVK_HI   = 32'h72A00000;
  localparam logic [31:0] ENC_MOV_REG   = 32'h2A0003E0;
  localparam logic [31:0] ENC_PUSH_LR   = 32'hF81F0FFE;
  localparam logic [31:0] ENC_POP_LR    = 32'hF84107FE;
  localparam logic [31:0] ENC_RET       = 32'hD65F03C0;
  localparam logic [31:0] ENC_BR_X15    = 32'hD61F01E0;
  localparam logic [31:0] ENC_BLR_X12   = 32'hD63F0180;
  localparam logic [31:0] ENC_BLR_X15   = 32'hD63F01E0;
  localparam logic [31:0] ENC_ADR_X13   = 32'h1000004D;
  localparam logic [31:0] ENC_ADD_X9    = 32'h8B000389;
  localparam logic [31:0] ENC_CMP       = 32'h7100001F;
  localparam logic [31:0] ENC_CSEL      = 32'h1A800000;
  localparam logic [31:0] ENC_CSEL_NE   = 32'h00001000;
  localparam logic [31:0] ENC_LDR_IDX   = 32'hB8605920;
  localparam logic [31:0] ENC_STR_IDX   = 32'hB8205920;
  localparam logic [31:0] ENC_ADD_W     = 32'h0B000000;
  localparam logic [31:0] ENC_MADD      = 32'h1B000000;
  localparam logic [31:0] ENC_MADD_WZR  = 32'h00007C00;
  localparam logic [31:0] ENC_UDIV      = 32'h1AC00800;
  localparam logic [31:0] ENC_AND_W     = 32'h0A000000;
  localparam logic [31:0] ENC_ORN_W     = 32'h2A2003E0;
  localparam logic [31:0] ENC_MOVZ_X27  = 32'hD280001B;
  localparam logic [31:0] ENC_MOV_W10   = 32'h2A0003EA;
  localparam logic [31:0] ENC_CBNZ      = 32'h35000040;
  localparam logic [4:0]  SCRATCH_W9    = 5'd9;

  typedef struct packed {
    logic [4:0][31:0] words;
    logic [24:0]      nxt;
  } slot_t;

  logic [4:0]  host_base;
  logic [4:0]  svc_reg;
  logic [15:0] out_svc;
  logic [15:0] in_svc;
  logic [15:0] unmap_svc;
  slot_t       expected_slots[$];
  int          slot_seq;

  // 5-bit add, so large bases wrap around
  function automatic logic [4:0] host_reg(input logic [2:0] idx);
    return host_base + 5'(idx);
  endfunction

  function automatic logic [31:0] svc_move(input logic [15:0] code);
    return ENC_MOVZ | (32'(code) << 5) | 32'(svc_reg);
  endfunction

  function automatic slot_t predict_slot(input logic [31:0] w, input logic [23:0] off);
    slot_t      s;
    logic [4:0] ra;
    logic [4:0] rb;
    logic [4:0] rc;
    logic [4:0] rd;
    logic [24:0] imm;
    ra = host_reg(w[8:6]);
    rb = host_reg(w[5:3]);
    rc = host_reg(w[2:0]);
    rd = host_reg(w[27:25]);
    imm = w[24:0];
    for (int i = 0; i < 5; i++) s.words[i] = ENC_NOP;
    case (w[31:28])
      OP_CMOV: begin
        s.words[0] = ENC_CMP | (32'(rc) << 5);
        s.words[1] = ENC_CSEL | 32'(ra) | (32'(rb) << 5) | (32'(ra) << 16) | ENC_CSEL_NE;
      end
      OP_LOAD: begin
        s.words[0] = ENC_ADD_X9 | (32'(rb) << 16);
        s.words[1] = ENC_LDR_IDX | 32'(ra) | (32'(rc) << 16);
      end
      OP_STORE: begin
        s.words[0] = ENC_ADD_X9 | (32'(ra) << 16);
        s.words[1] = ENC_STR_IDX | 32'(rc) | (32'(rb) << 16);
      end
      OP_ADD: s.words[0] = ENC_ADD_W | 32'(ra) | (32'(rb) << 5) | (32'(rc) << 16);
      OP_MUL: begin
        s.words[0] = ENC_MADD | 32'(ra) | (32'(rb) << 5) | (32'(rc) << 16) | ENC_MADD_WZR;
      end
      OP_DIV: s.words[0] = ENC_UDIV | 32'(ra) | (32'(rb) << 5) | (32'(rc) << 16);
      OP_NAND: begin
        s.words[0] = ENC_AND_W | 32'(SCRATCH_W9) | (32'(rb) << 5) | (32'(rc) << 16);
        s.words[1] = ENC_ORN_W | 32'(ra) | (32'(SCRATCH_W9) << 16);
      end
      OP_HALT: begin
        s.words[0] = ENC_MOVZ_X27;
        s.words[1] = ENC_RET;
        s.words[2] = '0;
        s.words[3] = '0;
        s.words[4] = '0;
      end
      OP_MAP: begin
        s.words[0] = ENC_MOV_REG | (32'(rc) << 16);
        s.words[1] = ENC_PUSH_LR;
        s.words[2] = ENC_BLR_X12;
        s.words[3] = ENC_POP_LR;
        s.words[4] = ENC_MOV_REG | 32'(rb);
      end
      OP_SEGFREE: begin
        s.words[0] = ENC_MOV_REG | (32'(rc) << 16);
        s.words[1] = svc_move(unmap_svc);
        s.words[2] = ENC_PUSH_LR;
        s.words[3] = ENC_BLR_X15;
        s.words[4] = ENC_POP_LR;
      end
      OP_OUT: begin
        s.words[0] = ENC_MOV_REG | (32'(rc) << 16);
        s.words[1] = svc_move(out_svc);
        s.words[2] = ENC_ADR_X13;
        s.words[3] = ENC_BR_X15;
      end
      OP_IN: begin
        s.words[0] = svc_move(in_svc);
        s.words[1] = ENC_ADR_X13;
        s.words[2] = ENC_BR_X15;
        s.words[3] = ENC_MOV_REG | 32'(rc);
      end
      OP_LOADP: begin
        s.words[0] = ENC_MOV_W10 | (32'(rc) << 16);
        s.words[1] = ENC_CBNZ | 32'(rb);
        s.words[2] = ENC_RET;
        s.words[3] = ENC_MOV_REG | (32'(rb) << 16);
        s.words[4] = ENC_BR_X15;
      end
      OP_LOADV: begin
        s.words[0] = ENC_MOVZ | (32'(imm[15:0]) << 5) | 32'(rd);
        s.words[1] = ENC_MOVK_HI | (32'(imm[24:16]) << 5) | 32'(rd);
      end
      default: s.words = '0;  // invalid opcode: empty slot
    endcase
    s.nxt = 25'(off) + 25'd20;
    return s;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("slot %0d %s: expected %h, got %h", slot_seq, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    slot_t got;
    slot_t want;
    if (rst) begin
      host_base = 5'd19;
      svc_reg = 5'd1;
      out_svc = 16'd0;
      in_svc = 16'd1;
      unmap_svc = 16'd2;
      expected_slots.delete();
      slot_seq = 0;
      error_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_REG:   host_base = cfg_data[4:0];
          CFG_ARG_REG:    svc_reg = cfg_data[4:0];
          CFG_OUT_CODE:   out_svc = cfg_data;
          CFG_IN_CODE:    in_svc = cfg_data;
          CFG_UNMAP_CODE: unmap_svc = cfg_data;
          default: ;
        endcase
      end
      // compare before pushing so a result cannot hide behind a new entry
      if (out_valid && out_ready) begin
        got.words[0] = host_word0;
        got.words[1] = host_word1;
        got.words[2] = host_word2;
        got.words[3] = host_word3;
        got.words[4] = host_word4;
        got.nxt = next_offset;
        if (expected_slots.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("slot %0d arrived with no transaction outstanding", slot_seq);
        end else begin
          want = expected_slots.pop_front();
          for (int i = 0; i < 5; i++)
            if (got.words[i] !== want.words[i])
              report_mismatch($sformatf("host_word%0d", i), want.words[i], got.words[i]);
          if (got.nxt !== want.nxt)
            report_mismatch("next_offset", 32'(want.nxt), 32'(got.nxt));
        end
        slot_seq++;
      end
      if (in_valid && in_ready)
        expected_slots.push_back(predict_slot(guest_instruction, code_offset));
    end
    in_flight <= expected_slots.size();
  end

endmodule

FILE: tb/tb_um_to_arm64_instruction_translator.sv
// Top of the translator testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_um_to_arm64_instruction_translator;
  import umtr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_ITEMS = 260;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] guest_instruction;
  logic [23:0] code_offset;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] host_word0;
  logic [31:0] host_word1;
  logic [31:0] host_word2;
  logic [31:0] host_word3;
  logic [31:0] host_word4;
  logic [24:0] next_offset;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        hold_toggle;
  logic [23:0] stream_offset;
  int          error_count;
  int          in_flight;

  um_to_arm64_instruction_translator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .guest_instruction(guest_instruction), .code_offset(code_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .host_word0(host_word0), .host_word1(host_word1), .host_word2(host_word2),
    .host_word3(host_word3), .host_word4(host_word4), .next_offset(next_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  um_slot_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .guest_instruction(guest_instruction), .code_offset(code_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .host_word0(host_word0), .host_word1(host_word1), .host_word2(host_word2),
    .host_word3(host_word3), .host_word4(host_word4), .next_offset(next_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .in_flight(in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // valid stays up across back-to-back transactions; callers lower it on a gap
  task automatic send_instr(input logic [31:0] word, input logic [23:0] off);
    in_valid <= 1'b1;
    guest_instruction <= word;
    code_offset <= off;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [15:0] base, input logic [15:0] arg,
                              input logic [15:0] outc, input logic [15:0] inc,
                              input logic [15:0] unmapc);
    write_reg(CFG_BASE_REG, base);
    write_reg(CFG_ARG_REG, arg);
    write_reg(CFG_OUT_CODE, outc);
    write_reg(CFG_IN_CODE, inc);
    write_reg(CFG_UNMAP_CODE, unmapc);
    // an index past the last register must be harmless
    write_reg(3'(CFG_UNMAP_CODE + 3'($urandom_range(1, 3))), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (in_flight != 0);
  endtask

  function automatic logic [31:0] random_guest_word();
    return {4'($urandom_range(0, 15)), 28'($urandom)};
  endfunction

  // mostly a contiguous code buffer, with jumps and runs near the top of the range
  function automatic logic [23:0] next_stream_offset();
    case ($urandom_range(0, 15))
      0: stream_offset = 24'($urandom);
      1: stream_offset = 24'hFFFFFF - 24'($urandom_range(0, 40));
      default: stream_offset = stream_offset + 24'd20;
    endcase
    return stream_offset;
  endfunction

  task automatic send_directed();
    int k;
    // every opcode, alternating all-zero and all-one operand and unused bits
    for (k = 0; k < 16; k++)
      send_instr({4'(k), (k % 2 == 1) ? 28'hFFFFFFF : 28'h0000000},
                 (k == 15) ? 24'hFFFFFF : 24'(k * 20));
    send_instr({OP_LOADV, 3'd0, 25'h0000000}, 24'hFFFFEC);
    send_instr({OP_LOADV, 3'd5, 25'h0010000}, 24'h000000);
    send_instr({OP_LOADV, 3'd2, 25'h000FFFF}, 24'h123456);
    send_instr({OP_ADD, 19'h5A5A5, 3'd1, 3'd2, 3'd3}, 24'h800000);
    send_instr({OP_CMOV, 19'h00000, 3'd7, 3'd0, 3'd7}, 24'h7FFFFF);
    send_instr({OP_NAND, 19'h7FFFF, 3'd0, 3'd7, 3'd3}, 24'h000014);
    send_instr({OP_IN, 19'h00000, 3'd0, 3'd0, 3'd7}, 24'hABCDEF);
    in_valid <= 1'b0;
  endtask

  task automatic run_stream(input int count, input bit squeeze);
    int sent;
    int burst;
    int gap;
    int k;
    sent = 0;
    if (squeeze) hold_toggle <= ~hold_toggle;
    while (sent < count) begin
      if (squeeze && sent == 0)
        burst = 48;  // keep offering while the receiver holds off
      else if ($urandom_range(0, 3) == 0)
        burst = $urandom_range(30, 60);
      else
        burst = $urandom_range(1, 12);
      for (k = 0; k < burst && sent < count; k++) begin
        send_instr(random_guest_word(), next_stream_offset());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // receiver: random stall modes in segments, plus long hold-offs on request
  initial begin : receiver
    int  seg_left;
    int  mode;
    int  phase;
    logic hold_seen;
    seg_left = 0;
    mode = 0;
    phase = 0;
    hold_seen = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 64);
        phase = 0;
      end
      seg_left--;
      phase++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (phase % 4 == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_um_to_arm64_instruction_translator failed");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;
    in_valid <= 1'b0;
    guest_instruction <= '0;
    code_offset <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BASE_REG;
    cfg_data <= '0;
    hold_toggle <= 1'b0;
    stream_offset = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_directed();
    drain();

    program_regs(16'd0, 16'd0, 16'h0000, 16'h0000, 16'h0000);
    run_stream(PHASE_ITEMS, 1'b1);
    drain();

    program_regs(16'd24, 16'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_directed();
    run_stream(PHASE_ITEMS, 1'b0);
    drain();

    // base past 24 exercises register number wrap
    program_regs(16'(16'hFFE0 | $urandom_range(25, 31)), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
    run_stream(PHASE_ITEMS, 1'b1);
    drain();

    repeat (2) begin
      program_regs(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
      run_stream(PHASE_ITEMS, 1'b0);
      drain();
    end

    repeat (6) @(posedge clk);
    if (error_count == 0)
      $display("tb_um_to_arm64_instruction_translator passed");
    else
      $display("tb_um_to_arm64_instruction_translator failed");
    $finish;
  end

endmodule
